FILE: hdl/a4sd_pkg.sv
// ----------------------------------------------------------------------------
// a4sd_pkg: shared types and constants for the A4* minimum image distance
// Field widths, stage counts, beat structs and the fixed-point scale table.
// ----------------------------------------------------------------------------
package a4sd_pkg;

   // Field widths
   localparam int COORD_W     = 7;
   localparam int EXTENT_W    = 7;
   localparam int MIN_FORM_W  = 18;
   localparam int DIST_W      = 24;

   // Internal widths
   localparam int IMG_W       = 9;                 // shifted coordinate, -191..190
   localparam int SQ_W        = 16;                // square of one shifted coordinate
   localparam int PAIR_W      = IMG_W + 1;
   localparam int PAIR_SQ_W   = SQ_W + 1;
   localparam int SUM_W       = PAIR_W + 1;
   localparam int SUM_SQ_W    = PAIR_SQ_W + 1;
   localparam int DIFF_W      = SUM_SQ_W + 2;      // 5*S2 - S1^2 = 2*K
   localparam int FORM_W      = 16;                // minimum K never exceeds 40960
   localparam int RAD_W       = 2 * DIST_W;
   localparam int REM_W       = DIST_W + 2;

   // Lattice geometry
   localparam int NUM_AXES    = 4;
   localparam int NUM_SHIFTS  = 3;
   localparam int NUM_PAIRS   = NUM_SHIFTS * NUM_SHIFTS;
   localparam int NUM_LANES   = NUM_PAIRS * NUM_PAIRS;
   localparam int TREE1_N     = NUM_LANES / 3;
   localparam int TREE2_N     = TREE1_N / 3;
   localparam int TREE3_N     = TREE2_N / 3;

   // Bound on 2*K set by the unshifted image with coordinates of magnitude 64
   localparam logic [DIFF_W-1:0] DIFF_MAX = DIFF_W'(81920);

   // Division by five: q = (K * 0xCCCD) >> 18 is exact for 16-bit K
   localparam logic [FORM_W-1:0] FIFTH_RECIP = 16'hCCCD;
   localparam int FIFTH_SHIFT = 18;
   localparam int QUOT_W      = 2 * FORM_W - FIFTH_SHIFT;
   localparam int REM5_W      = 3;
   localparam int FRAC_SHIFT  = 33;

   // Pipeline depth
   localparam int FORM_STAGES  = 9;
   localparam int SCALE_STAGES = 2;
   localparam int LATENCY      = FORM_STAGES + SCALE_STAGES + DIST_W;

   // Register map
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTENT_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTENT_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTENT_Z = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTENT_T = 2'd3;
   localparam logic [EXTENT_W-1:0] EXTENT_RESET = 7'd8;

   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;
   localparam int AXIS_T = 3;

   typedef struct packed {
      logic                                valid;
      logic [NUM_AXES-1:0][COORD_W-1:0]    coord;
   } coord_beat_type;

   typedef struct packed {
      logic                valid;
      logic [DIFF_W-1:0]   diff;
   } diff_beat_type;

   typedef struct packed {
      logic                valid;
      logic [RAD_W-1:0]    rad;
      logic [FORM_W-1:0]   tag;
   } rad_beat_type;

   typedef struct packed {
      logic                valid;
      logic [DIST_W-1:0]   root;
      logic [FORM_W-1:0]   tag;
   } root_beat_type;

   // floor(r * 2^33 / 5) for a remainder r of a division by five
   function automatic logic [FRAC_SHIFT-1:0] frac_fifth(input logic [REM5_W-1:0] r);
      logic [FRAC_SHIFT-1:0] v;
      unique case (r)
         3'd0:    v = 33'd0;
         3'd1:    v = 33'd1717986918;
         3'd2:    v = 33'd3435973836;
         3'd3:    v = 33'd5153960755;
         3'd4:    v = 33'd6871947673;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/a4sd_form_min.sv
// ----------------------------------------------------------------------------
// a4sd_form_min: minimum quadratic form over the 81 periodic images
// Builds the three images per axis, forms 2*K = 5*S2 - S1^2 in 81 lanes and
// reduces them through a registered three-way minimum tree. Nine stages.
// ----------------------------------------------------------------------------
module a4sd_form_min (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  a4sd_pkg::coord_beat_type                                in_beat,
   input  logic [a4sd_pkg::NUM_AXES-1:0][a4sd_pkg::EXTENT_W-1:0]   extents,
   output a4sd_pkg::diff_beat_type                                 out_beat
);

   localparam int NA = a4sd_pkg::NUM_AXES;
   localparam int NS = a4sd_pkg::NUM_SHIFTS;
   localparam int NP = a4sd_pkg::NUM_PAIRS;
   localparam int NL = a4sd_pkg::NUM_LANES;
   localparam int T1 = a4sd_pkg::TREE1_N;
   localparam int T2 = a4sd_pkg::TREE2_N;
   localparam int T3 = a4sd_pkg::TREE3_N;

   function automatic logic [a4sd_pkg::DIFF_W-1:0] min3(
      input logic [a4sd_pkg::DIFF_W-1:0] a,
      input logic [a4sd_pkg::DIFF_W-1:0] b,
      input logic [a4sd_pkg::DIFF_W-1:0] c
   );
      logic [a4sd_pkg::DIFF_W-1:0] m;
      m = (a < b) ? a : b;
      return (c < m) ? c : m;
   endfunction

   logic [a4sd_pkg::FORM_STAGES-1:0] valid_ff;
   logic [a4sd_pkg::FORM_STAGES-1:0] valid_in;

   // Stage 1: input capture
   logic [NA-1:0][a4sd_pkg::COORD_W-1:0]  coord_ff;
   logic [NA-1:0][a4sd_pkg::EXTENT_W-1:0] extent_ff;

   // Stage 2: shifted coordinates and their squares
   logic signed [a4sd_pkg::IMG_W-1:0]     img_in   [NA][NS];
   logic signed [a4sd_pkg::IMG_W-1:0]     img_ff   [NA][NS];
   logic signed [2*a4sd_pkg::IMG_W-1:0]   img_prod [NA][NS];
   logic [a4sd_pkg::SQ_W-1:0]             sq_in    [NA][NS];
   logic [a4sd_pkg::SQ_W-1:0]             sq_ff    [NA][NS];

   // Stage 3: xy and zt pair sums
   logic signed [a4sd_pkg::PAIR_W-1:0]    pxy_in [NP];
   logic signed [a4sd_pkg::PAIR_W-1:0]    pxy_ff [NP];
   logic signed [a4sd_pkg::PAIR_W-1:0]    pzt_in [NP];
   logic signed [a4sd_pkg::PAIR_W-1:0]    pzt_ff [NP];
   logic [a4sd_pkg::PAIR_SQ_W-1:0]        qxy_in [NP];
   logic [a4sd_pkg::PAIR_SQ_W-1:0]        qxy_ff [NP];
   logic [a4sd_pkg::PAIR_SQ_W-1:0]        qzt_in [NP];
   logic [a4sd_pkg::PAIR_SQ_W-1:0]        qzt_ff [NP];

   // Stage 4: per-lane S1 and S2
   logic signed [a4sd_pkg::SUM_W-1:0]     s1_in [NL];
   logic signed [a4sd_pkg::SUM_W-1:0]     s1_ff [NL];
   logic [a4sd_pkg::SUM_SQ_W-1:0]         s2_in [NL];
   logic [a4sd_pkg::SUM_SQ_W-1:0]         s2_ff [NL];

   // Stage 5: per-lane 2*K
   logic signed [2*a4sd_pkg::SUM_W-1:0]   s1_prod [NL];
   logic [a4sd_pkg::DIFF_W-1:0]           five_s2 [NL];
   logic [2*a4sd_pkg::SUM_W-1:0]          diff_full [NL];
   logic [a4sd_pkg::DIFF_W-1:0]           diff_in [NL];
   logic [a4sd_pkg::DIFF_W-1:0]           diff_ff [NL];

   // Stages 6..9: minimum tree
   logic [a4sd_pkg::DIFF_W-1:0]           t1_in [T1];
   logic [a4sd_pkg::DIFF_W-1:0]           t1_ff [T1];
   logic [a4sd_pkg::DIFF_W-1:0]           t2_in [T2];
   logic [a4sd_pkg::DIFF_W-1:0]           t2_ff [T2];
   logic [a4sd_pkg::DIFF_W-1:0]           t3_in [T3];
   logic [a4sd_pkg::DIFF_W-1:0]           t3_ff [T3];
   logic [a4sd_pkg::DIFF_W-1:0]           t4_in;
   logic [a4sd_pkg::DIFF_W-1:0]           t4_ff;

   assign valid_in = {valid_ff[a4sd_pkg::FORM_STAGES-2:0], in_beat.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coord_ff  <= in_beat.coord;
      extent_ff <= extents;
   end

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         img_in[a][0] = a4sd_pkg::IMG_W'($signed(coord_ff[a]))
                      - $signed(a4sd_pkg::IMG_W'(extent_ff[a]));
         img_in[a][1] = a4sd_pkg::IMG_W'($signed(coord_ff[a]));
         img_in[a][2] = a4sd_pkg::IMG_W'($signed(coord_ff[a]))
                      + $signed(a4sd_pkg::IMG_W'(extent_ff[a]));
         for (int s = 0; s < NS; s++) begin
            img_prod[a][s] = img_in[a][s] * img_in[a][s];
            sq_in[a][s]    = img_prod[a][s][a4sd_pkg::SQ_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      img_ff <= img_in;
      sq_ff  <= sq_in;
   end

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         for (int j = 0; j < NS; j++) begin
            pxy_in[i*NS+j] = a4sd_pkg::PAIR_W'(img_ff[a4sd_pkg::AXIS_X][i])
                           + a4sd_pkg::PAIR_W'(img_ff[a4sd_pkg::AXIS_Y][j]);
            pzt_in[i*NS+j] = a4sd_pkg::PAIR_W'(img_ff[a4sd_pkg::AXIS_Z][i])
                           + a4sd_pkg::PAIR_W'(img_ff[a4sd_pkg::AXIS_T][j]);
            qxy_in[i*NS+j] = a4sd_pkg::PAIR_SQ_W'(sq_ff[a4sd_pkg::AXIS_X][i])
                           + a4sd_pkg::PAIR_SQ_W'(sq_ff[a4sd_pkg::AXIS_Y][j]);
            qzt_in[i*NS+j] = a4sd_pkg::PAIR_SQ_W'(sq_ff[a4sd_pkg::AXIS_Z][i])
                           + a4sd_pkg::PAIR_SQ_W'(sq_ff[a4sd_pkg::AXIS_T][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      pxy_ff <= pxy_in;
      pzt_ff <= pzt_in;
      qxy_ff <= qxy_in;
      qzt_ff <= qzt_in;
   end

   always_comb begin
      for (int p = 0; p < NP; p++) begin
         for (int q = 0; q < NP; q++) begin
            s1_in[p*NP+q] = a4sd_pkg::SUM_W'(pxy_ff[p]) + a4sd_pkg::SUM_W'(pzt_ff[q]);
            s2_in[p*NP+q] = a4sd_pkg::SUM_SQ_W'(qxy_ff[p])
                          + a4sd_pkg::SUM_SQ_W'(qzt_ff[q]);
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   // 2*K = 5*S2 - S1^2; the form is positive semidefinite, so this never wraps
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         s1_prod[l]   = s1_ff[l] * s1_ff[l];
         five_s2[l]   = {s2_ff[l], 2'b00} + {2'b00, s2_ff[l]};
         diff_full[l] = {2'b00, five_s2[l]} - $unsigned(s1_prod[l]);
         diff_in[l]   = diff_full[l][a4sd_pkg::DIFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

   always_comb begin
      for (int i = 0; i < T1; i++) begin
         t1_in[i] = min3(diff_ff[3*i], diff_ff[3*i+1], diff_ff[3*i+2]);
      end
      for (int i = 0; i < T2; i++) begin
         t2_in[i] = min3(t1_ff[3*i], t1_ff[3*i+1], t1_ff[3*i+2]);
      end
      for (int i = 0; i < T3; i++) begin
         t3_in[i] = min3(t2_ff[3*i], t2_ff[3*i+1], t2_ff[3*i+2]);
      end
      t4_in = min3(t3_ff[0], t3_ff[1], t3_ff[2]);
   end

   always_ff @(posedge clock) begin
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      t3_ff <= t3_in;
      t4_ff <= t4_in;
   end

   assign out_beat.valid = valid_ff[a4sd_pkg::FORM_STAGES-1];
   assign out_beat.diff  = t4_ff;

`ifndef NO_ASSERTIONS
   a_diff_even: assert property (@(posedge clock) disable iff (reset)
      out_beat.valid |-> !out_beat.diff[0])
      else $error("minimum of 5*S2 - S1^2 is odd");

   a_diff_bound: assert property (@(posedge clock) disable iff (reset)
      out_beat.valid |-> out_beat.diff <= a4sd_pkg::DIFF_MAX)
      else $error("minimum exceeds the unshifted image bound");
`endif

endmodule

FILE: hdl/a4sd_isqrt.sv
// ----------------------------------------------------------------------------
// a4sd_isqrt: pipelined integer square root
// One result bit per stage, restoring digit recurrence, a tag rides along.
// ----------------------------------------------------------------------------
module a4sd_isqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  a4sd_pkg::rad_beat_type   in_beat,
   output a4sd_pkg::root_beat_type  out_beat
);

   localparam int NB = a4sd_pkg::DIST_W;

   logic                            valid_ff [NB];
   logic [a4sd_pkg::RAD_W-1:0]      rad_ff   [NB];
   logic [a4sd_pkg::REM_W-1:0]      rem_ff   [NB];
   logic [NB-1:0]                   root_ff  [NB];
   logic [a4sd_pkg::FORM_W-1:0]     tag_ff   [NB];

   for (genvar g = 0; g < NB; g++) begin : g_step
      logic                         src_valid;
      logic [a4sd_pkg::RAD_W-1:0]   src_rad;
      logic [a4sd_pkg::REM_W-1:0]   src_rem;
      logic [NB-1:0]                src_root;
      logic [a4sd_pkg::FORM_W-1:0]  src_tag;
      logic [a4sd_pkg::REM_W+1:0]   cur;
      logic [a4sd_pkg::REM_W+1:0]   trial;
      logic                         fits;
      logic [a4sd_pkg::REM_W-1:0]   rem_in;

      if (g == 0) begin : g_head
         assign src_valid = in_beat.valid;
         assign src_rad   = in_beat.rad;
         assign src_rem   = '0;
         assign src_root  = '0;
         assign src_tag   = in_beat.tag;
      end else begin : g_body
         assign src_valid = valid_ff[g-1];
         assign src_rad   = rad_ff[g-1];
         assign src_rem   = rem_ff[g-1];
         assign src_root  = root_ff[g-1];
         assign src_tag   = tag_ff[g-1];
      end

      // bring down the next two radicand bits and try root*4 + 1
      assign cur    = {src_rem, src_rad[a4sd_pkg::RAD_W-1 -: 2]};
      assign trial  = (a4sd_pkg::REM_W + 2)'({src_root, 2'b01});
      assign fits   = (cur >= trial);
      assign rem_in = fits ? a4sd_pkg::REM_W'(cur - trial) : a4sd_pkg::REM_W'(cur);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[g]  <= src_rad << 2;
         rem_ff[g]  <= rem_in;
         root_ff[g] <= {src_root[NB-2:0], fits};
         tag_ff[g]  <= src_tag;
      end
   end

   assign out_beat.valid = valid_ff[NB-1];
   assign out_beat.root  = root_ff[NB-1];
   assign out_beat.tag   = tag_ff[NB-1];

endmodule

FILE: hdl/a4star_min_image_distance.sv
// ----------------------------------------------------------------------------
// a4star_min_image_distance: minimum image distance on a periodic A4* lattice
// Smallest quadratic form over 81 periodic images and its Q8.16 distance.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_dx/dy/dz/dt and raise start; a beat is taken at every rising
//   edge where start is high and busy is low. busy is low except while reset
//   is asserted, so one displacement can enter every cycle.
//   Each beat yields one result: rsp_strobe is
//   high for exactly one cycle with rsp_min_form (smallest K) and
//   rsp_distance = floor(65536*sqrt(0.4*K)). Results leave in input order.
//   The pipeline is 9 stages of image forms and minimum tree, 2 stages of scaling
//   by 2^33/5 and 24 stages of the bit-per-stage square root.
//   The result side has no backpressure: the pipeline advances every cycle.
//   Extents are written through csr_we/csr_index/csr_wdata, one register
//   per write, and are sampled when a beat enters; write them only while no
//   beat is in flight.
//   Reset (synchronous) drops every beat in flight and sets all extents to 8.
// ----------------------------------------------------------------------------
module a4star_min_image_distance (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [a4sd_pkg::COORD_W-1:0]    req_dx,
   input  logic signed [a4sd_pkg::COORD_W-1:0]    req_dy,
   input  logic signed [a4sd_pkg::COORD_W-1:0]    req_dz,
   input  logic signed [a4sd_pkg::COORD_W-1:0]    req_dt,
   output logic                                   rsp_strobe,
   output logic [a4sd_pkg::MIN_FORM_W-1:0]        rsp_min_form,
   output logic [a4sd_pkg::DIST_W-1:0]            rsp_distance,
   input  logic                                   csr_we,
   input  logic [a4sd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [a4sd_pkg::EXTENT_W-1:0]          csr_wdata
);

   logic [a4sd_pkg::NUM_AXES-1:0][a4sd_pkg::EXTENT_W-1:0] extent_ff;
   logic [a4sd_pkg::NUM_AXES-1:0][a4sd_pkg::EXTENT_W-1:0] extent_in;

   a4sd_pkg::coord_beat_type  coord_beat;
   a4sd_pkg::diff_beat_type   diff_beat;
   a4sd_pkg::rad_beat_type    rad_beat;
   a4sd_pkg::root_beat_type   root_beat;

   // Scaling stage A: K and K * reciprocal of five
   logic                               sa_valid_ff;
   logic [a4sd_pkg::FORM_W-1:0]        sa_form_ff;
   logic [a4sd_pkg::FORM_W-1:0]        sa_form_in;
   logic [2*a4sd_pkg::FORM_W-1:0]      sa_prod_ff;
   logic [2*a4sd_pkg::FORM_W-1:0]      sa_prod_in;

   // Scaling stage B: radicand floor(K * 2^33 / 5)
   logic                               sb_valid_ff;
   logic [a4sd_pkg::FORM_W-1:0]        sb_form_ff;
   logic [a4sd_pkg::RAD_W-1:0]         sb_rad_ff;
   logic [a4sd_pkg::RAD_W-1:0]         sb_rad_in;
   logic [a4sd_pkg::QUOT_W-1:0]        quot;
   logic [a4sd_pkg::FORM_W-1:0]        five_quot;
   logic [a4sd_pkg::FORM_W-1:0]        rem_full;
   logic [a4sd_pkg::REM5_W-1:0]        rem5;

   assign busy = reset;

   always_comb begin
      extent_in = extent_ff;
      if (csr_we) begin
         unique case (csr_index)
            a4sd_pkg::CSR_EXTENT_X: extent_in[a4sd_pkg::AXIS_X] = csr_wdata;
            a4sd_pkg::CSR_EXTENT_Y: extent_in[a4sd_pkg::AXIS_Y] = csr_wdata;
            a4sd_pkg::CSR_EXTENT_Z: extent_in[a4sd_pkg::AXIS_Z] = csr_wdata;
            a4sd_pkg::CSR_EXTENT_T: extent_in[a4sd_pkg::AXIS_T] = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         extent_ff <= {a4sd_pkg::NUM_AXES{a4sd_pkg::EXTENT_RESET}};
      end else begin
         extent_ff <= extent_in;
      end
   end

   always_comb begin
      coord_beat.valid                   = start && !busy;
      coord_beat.coord[a4sd_pkg::AXIS_X] = req_dx;
      coord_beat.coord[a4sd_pkg::AXIS_Y] = req_dy;
      coord_beat.coord[a4sd_pkg::AXIS_Z] = req_dz;
      coord_beat.coord[a4sd_pkg::AXIS_T] = req_dt;
   end

   a4sd_form_min u_form_min (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (coord_beat),
      .extents  (extent_ff),
      .out_beat (diff_beat)
   );

   // K = (2*K) / 2; the low bit is always zero
   assign sa_form_in = diff_beat.diff[a4sd_pkg::FORM_W:1];
   assign sa_prod_in = sa_form_in * a4sd_pkg::FIFTH_RECIP;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
         sb_valid_ff <= 1'b0;
      end else begin
         sa_valid_ff <= diff_beat.valid;
         sb_valid_ff <= sa_valid_ff;
      end
   end

   // K*2^33/5 = q*2^33 + floor(r*2^33/5) with K = 5q + r
   always_comb begin
      quot      = sa_prod_ff[a4sd_pkg::FIFTH_SHIFT +: a4sd_pkg::QUOT_W];
      five_quot = a4sd_pkg::FORM_W'({quot, 2'b00}) + a4sd_pkg::FORM_W'(quot);
      rem_full  = sa_form_ff - five_quot;
      rem5      = rem_full[a4sd_pkg::REM5_W-1:0];
      sb_rad_in = a4sd_pkg::RAD_W'({quot, {a4sd_pkg::FRAC_SHIFT{1'b0}}})
                + a4sd_pkg::RAD_W'(a4sd_pkg::frac_fifth(rem5));
   end

   always_ff @(posedge clock) begin
      sa_form_ff <= sa_form_in;
      sa_prod_ff <= sa_prod_in;
      sb_form_ff <= sa_form_ff;
      sb_rad_ff  <= sb_rad_in;
   end

   always_comb begin
      rad_beat.valid = sb_valid_ff;
      rad_beat.rad   = sb_rad_ff;
      rad_beat.tag   = sb_form_ff;
   end

   a4sd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (rad_beat),
      .out_beat (root_beat)
   );

   assign rsp_strobe   = root_beat.valid;
   assign rsp_min_form = a4sd_pkg::MIN_FORM_W'(root_beat.tag);
   assign rsp_distance = root_beat.root;

`ifndef NO_ASSERTIONS
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(a4sd_pkg::LATENCY) rsp_strobe)
      else $error("accepted beat did not produce a result on time");

   a_root_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         ((64'(rsp_distance) * 64'(rsp_distance) * 64'd5)
            <= (64'(rsp_min_form) << a4sd_pkg::FRAC_SHIFT))
         && (((64'(rsp_distance) + 64'd1) * (64'(rsp_distance) + 64'd1) * 64'd5)
            > (64'(rsp_min_form) << a4sd_pkg::FRAC_SHIFT)))
      else $error("distance is not the floored root of 0.4*K");
`endif

endmodule
